>>> hdl/risc_instruction_execute_core_defines.svh
// Assertion macros for the execute core.
// Used by the top level only; needs nothing else.
`ifndef RISC_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define RISC_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH

// same-cycle implication
`define RICE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RICE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rice_pkg.sv
// Shared types, opcodes and helpers for the execute core.
// No dependencies.
`timescale 1ns / 1ps
package rice_pkg;

    localparam int NUM_REGS     = 32;
    localparam int CTL_STATUS   = 0;
    localparam int CTL_ESTATUS  = 1;
    localparam int CTL_IENABLE  = 3;
    localparam int CTL_IPENDING = 4;
    localparam logic [4:0] REG_EA = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;
    localparam logic [31:0] VEC_RESET = 32'h0000_0020;
    localparam logic [0:0] CFG_START  = 1'b0;
    localparam logic [0:0] CFG_VECTOR = 1'b1;

    typedef enum logic [4:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NOR,
        ALU_SLL, ALU_SRL, ALU_SRA, ALU_ROL, ALU_ROR,
        ALU_LTS, ALU_LTU, ALU_GES, ALU_GEU, ALU_EQ, ALU_NE
    } t_alu_op;

    typedef struct packed {
        logic start;
        logic sgn;
    } t_div_ctl;

    localparam logic [2:0] KIND_BU = 3'd0;
    localparam logic [2:0] KIND_BS = 3'd1;
    localparam logic [2:0] KIND_HU = 3'd2;
    localparam logic [2:0] KIND_HS = 3'd3;
    localparam logic [2:0] KIND_W  = 3'd4;

    localparam logic [1:0] SIZE_B = 2'd0;
    localparam logic [1:0] SIZE_H = 2'd1;
    localparam logic [1:0] SIZE_W = 2'd2;

    // I/J-type opcodes
    localparam logic [5:0] OP_CALL = 6'h00, OP_JMPI = 6'h01, OP_RTYPE = 6'h3a;
    localparam logic [5:0] OP_LDBU = 6'h03, OP_LDBUIO = 6'h23;
    localparam logic [5:0] OP_LDB = 6'h07, OP_LDBIO = 6'h27;
    localparam logic [5:0] OP_LDHU = 6'h0b, OP_LDHUIO = 6'h2b;
    localparam logic [5:0] OP_LDH = 6'h0f, OP_LDHIO = 6'h2f;
    localparam logic [5:0] OP_LDW = 6'h17, OP_LDWIO = 6'h37;
    localparam logic [5:0] OP_STB = 6'h05, OP_STBIO = 6'h25;
    localparam logic [5:0] OP_STH = 6'h0d, OP_STHIO = 6'h2d;
    localparam logic [5:0] OP_STW = 6'h15, OP_STWIO = 6'h35;
    localparam logic [5:0] OP_ADDI = 6'h04, OP_BR = 6'h06, OP_CMPGEI = 6'h08;
    localparam logic [5:0] OP_ANDI = 6'h0c, OP_BGE = 6'h0e, OP_CMPLTI = 6'h10;
    localparam logic [5:0] OP_ORI = 6'h14, OP_BLT = 6'h16, OP_CMPNEI = 6'h18;
    localparam logic [5:0] OP_XORI = 6'h1c, OP_BNE = 6'h1e, OP_CMPEQI = 6'h20;
    localparam logic [5:0] OP_MULI = 6'h24, OP_BEQ = 6'h26, OP_CMPGEUI = 6'h28;
    localparam logic [5:0] OP_ANDHI = 6'h2c, OP_BGEU = 6'h2e, OP_CMPLTUI = 6'h30;
    localparam logic [5:0] OP_ORHI = 6'h34, OP_BLTU = 6'h36, OP_XORHI = 6'h3c;

    // R-type extended opcodes
    localparam logic [5:0] OPX_ERET = 6'h01, OPX_ROLI = 6'h02, OPX_ROL = 6'h03;
    localparam logic [5:0] OPX_RET = 6'h05, OPX_NOR = 6'h06, OPX_MULXUU = 6'h07;
    localparam logic [5:0] OPX_CMPGE = 6'h08, OPX_ROR = 6'h0b, OPX_JMP = 6'h0d;
    localparam logic [5:0] OPX_AND = 6'h0e, OPX_CMPLT = 6'h10, OPX_SLLI = 6'h12;
    localparam logic [5:0] OPX_SLL = 6'h13, OPX_OR = 6'h16, OPX_MULXSU = 6'h17;
    localparam logic [5:0] OPX_CMPNE = 6'h18, OPX_SRLI = 6'h1a, OPX_SRL = 6'h1b;
    localparam logic [5:0] OPX_NEXTPC = 6'h1c, OPX_CALLR = 6'h1d, OPX_XOR = 6'h1e;
    localparam logic [5:0] OPX_MULXSS = 6'h1f, OPX_CMPEQ = 6'h20, OPX_DIVU = 6'h24;
    localparam logic [5:0] OPX_DIV = 6'h25, OPX_RDCTL = 6'h26, OPX_MUL = 6'h27;
    localparam logic [5:0] OPX_CMPGEU = 6'h28, OPX_TRAP = 6'h2d, OPX_WRCTL = 6'h2e;
    localparam logic [5:0] OPX_CMPLTU = 6'h30, OPX_ADD = 6'h31, OPX_BREAK = 6'h34;
    localparam logic [5:0] OPX_SUB = 6'h39, OPX_SRAI = 6'h3a, OPX_SRA = 6'h3b;

    function automatic logic [31:0] load_ext(input logic [2:0] kind, input logic [31:0] d);
        logic [31:0] v;
        unique case (kind)
            KIND_BU: v = {24'b0, d[7:0]};
            KIND_BS: v = {{24{d[7]}}, d[7:0]};
            KIND_HU: v = {16'b0, d[15:0]};
            KIND_HS: v = {{16{d[15]}}, d[15:0]};
            default: v = d;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/rice_in_if.sv
// Input channel: instruction or load-return word with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface rice_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] instr_word;
    logic [31:0] load_data;
    logic [31:0] irq_lines;

    modport source (output valid, func, instr_word, load_data, irq_lines, input ready);
    modport sink   (input valid, func, instr_word, load_data, irq_lines, output ready);
endinterface

>>> hdl/rice_out_if.sv
// Output channel: one result word per input word, valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface rice_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] fetch_pc;
    logic        mem_valid;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        awaiting_load;
    logic        cpu_halted;

    modport source (output valid, fetch_pc, mem_valid, mem_write, mem_size, mem_addr,
                    mem_wdata, awaiting_load, cpu_halted, input ready);
    modport sink   (input valid, fetch_pc, mem_valid, mem_write, mem_size, mem_addr,
                    mem_wdata, awaiting_load, cpu_halted, output ready);
endinterface

>>> hdl/rice_alu.sv
// Shared ALU: add/sub, logic, shifts, rotates and compares.
// Depends on rice_pkg.
`timescale 1ns / 1ps
module rice_alu (
    input  rice_pkg::t_alu_op i_op,
    input  logic [31:0]       i_x,
    input  logic [31:0]       i_y,
    output logic [31:0]       o_res
);
    import rice_pkg::*;

    logic [4:0] sh;
    logic [5:0] inv;

    assign sh  = i_y[4:0];
    assign inv = 6'd32 - {1'b0, sh};

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_res = i_x + i_y;
            ALU_SUB: o_res = i_x - i_y;
            ALU_AND: o_res = i_x & i_y;
            ALU_OR:  o_res = i_x | i_y;
            ALU_XOR: o_res = i_x ^ i_y;
            ALU_NOR: o_res = ~(i_x | i_y);
            ALU_SLL: o_res = i_x << sh;
            ALU_SRL: o_res = i_x >> sh;
            ALU_SRA: o_res = 32'($signed(i_x) >>> sh);
            ALU_ROL: o_res = (i_x << sh) | (i_x >> inv);
            ALU_ROR: o_res = (i_x >> sh) | (i_x << inv);
            ALU_LTS: o_res = {31'b0, $signed(i_x) < $signed(i_y)};
            ALU_LTU: o_res = {31'b0, i_x < i_y};
            ALU_GES: o_res = {31'b0, $signed(i_x) >= $signed(i_y)};
            ALU_GEU: o_res = {31'b0, i_x >= i_y};
            ALU_EQ:  o_res = {31'b0, i_x == i_y};
            ALU_NE:  o_res = {31'b0, i_x != i_y};
            default: o_res = '0;
        endcase
    end
endmodule

>>> hdl/rice_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, signed or unsigned.
// Depends on rice_pkg.
`timescale 1ns / 1ps
module rice_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rice_pkg::t_div_ctl i_ctl,
    input  logic [31:0]        i_dividend,
    input  logic [31:0]        i_divisor,
    output logic               o_done,
    output logic [31:0]        o_quot
);
    import rice_pkg::*;

    logic        r_busy, r_done, r_neg;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_div;
    logic [32:0] sh, diff;

    assign sh   = {r_rem, r_quo[31]};
    assign diff = sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= (i_ctl.sgn && i_dividend[31]) ? -i_dividend : i_dividend;
                r_div  <= (i_ctl.sgn && i_divisor[31]) ? -i_divisor : i_divisor;
                r_neg  <= i_ctl.sgn && (i_dividend[31] ^ i_divisor[31]);
            end else if (r_busy) begin
                r_rem <= diff[32] ? sh[31:0] : diff[31:0];
                r_quo <= {r_quo[30:0], ~diff[32]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -r_quo : r_quo;
endmodule

>>> hdl/risc_instruction_execute_core.sv
// Execute core top level: sequencer, register file, control registers, pc.
// Ignored and load-return words are answered from idle; other words read registered
// operands in the execute state, then multiply passes the multiply state and divide waits
// in the divide state for the 32-step divider. The next word is taken after the result.
// Reset (synchronous, active low): registers zero, pc 0, exception vector 0x20.
`timescale 1ns / 1ps
`include "risc_instruction_execute_core_defines.svh"
module risc_instruction_execute_core #(
    parameter int NUM_CTL_REGS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rice_in_if.sink           i_in,
    rice_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata
);
    import rice_pkg::*;

    localparam int CW = $clog2(NUM_CTL_REGS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    t_state      r_state;
    logic [31:0] r_pc, r_vec, r_iw;
    logic        r_halt, r_load_pend;
    logic [4:0]  r_load_dest, r_dest;
    logic [2:0]  r_load_kind;
    logic [31:0] r_ctl [NUM_CTL_REGS];
    logic [31:0] r_gpr [NUM_REGS];
    logic [NUM_REGS-1:0] r_gpr_vld;
    logic [31:0] r_a_raw, r_b_raw;
    logic        r_a_ok, r_b_ok;
    logic [63:0] r_prod;
    logic        r_mul_hi;

    logic        r_out_valid, r_o_mv, r_o_mw, r_o_wait, r_o_halt;
    logic [1:0]  r_o_ms;
    logic [31:0] r_o_pc, r_o_ma, r_o_md;

    logic        acc;
    logic [4:0]  rd_a;
    logic [31:0] a, b;
    logic [5:0]  op, opx;
    logic [4:0]  ra, rb, rc, i5;
    logic [15:0] u16;
    logic [31:0] s16, br_tgt;

    t_alu_op     alu_op;
    logic [31:0] alu_x, alu_y, alu_res;

    logic        wen, br, take_exc, eret, wrctl, halt, is_ld, is_st;
    logic        go_mul, mul_hi, sgn_a, sgn_b, go_div, div_sgn, irq_due, exc_now;
    logic [4:0]  dest;
    logic [31:0] wd, pc_n, md, ctl_rd, mul_y;
    logic [1:0]  size;
    logic [2:0]  kind;
    logic signed [32:0] mx, my;
    logic signed [65:0] prod_full;

    logic        gpr_we;
    logic [4:0]  gpr_wa;
    logic [31:0] gpr_wd;

    t_div_ctl    div_ctl;
    logic        div_done;
    logic [31:0] div_q;

    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign acc        = i_in.valid && i_in.ready;

    // eret and ret read their target on port A
    always_comb begin
        rd_a = i_in.instr_word[31:27];
        if (i_in.instr_word[5:0] == OP_RTYPE) begin
            if (i_in.instr_word[16:11] == OPX_ERET) rd_a = REG_EA;
            else if (i_in.instr_word[16:11] == OPX_RET) rd_a = REG_RA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_raw <= r_gpr[rd_a];
            r_b_raw <= r_gpr[i_in.instr_word[26:22]];
            r_a_ok  <= r_gpr_vld[rd_a];
            r_b_ok  <= r_gpr_vld[i_in.instr_word[26:22]];
        end
        if (gpr_we) r_gpr[gpr_wa] <= gpr_wd;
    end

    assign a   = r_a_ok ? r_a_raw : '0;
    assign b   = r_b_ok ? r_b_raw : '0;
    assign op  = r_iw[5:0];
    assign opx = r_iw[16:11];
    assign ra  = r_iw[31:27];
    assign rb  = r_iw[26:22];
    assign rc  = r_iw[21:17];
    assign i5  = r_iw[10:6];
    assign u16 = r_iw[21:6];
    assign s16 = {{16{u16[15]}}, u16};
    assign br_tgt = r_pc + s16;
    assign ctl_rd = ({1'b0, i5} < 6'(NUM_CTL_REGS)) ? r_ctl[i5[CW-1:0]] : '0;
    assign irq_due = r_ctl[CTL_STATUS][0] && |(r_ctl[CTL_IPENDING] & r_ctl[CTL_IENABLE]);

    rice_alu u_alu (.i_op(alu_op), .i_x(alu_x), .i_y(alu_y), .o_res(alu_res));

    always_comb begin
        alu_op = ALU_ADD; alu_x = a; alu_y = b;
        wen = 1'b0; dest = rb; wd = alu_res; pc_n = r_pc; br = 1'b0;
        take_exc = 1'b0; eret = 1'b0; wrctl = 1'b0; halt = 1'b0;
        is_ld = 1'b0; is_st = 1'b0; size = SIZE_B; kind = KIND_BU; md = '0;
        go_mul = 1'b0; mul_hi = 1'b0; sgn_a = 1'b0; sgn_b = 1'b0; mul_y = b;
        go_div = 1'b0; div_sgn = 1'b0;
        unique case (op)
            OP_CALL: begin
                wen = 1'b1; dest = REG_RA; wd = r_pc;
                pc_n = {r_pc[31:28], r_iw[31:6], 2'b00};
            end
            OP_JMPI: pc_n = {r_pc[31:28], r_iw[31:6], 2'b00};
            OP_RTYPE: begin
                dest = rc;
                unique case (opx)
                    OPX_ERET:   begin eret = 1'b1; pc_n = a; end
                    OPX_RET, OPX_JMP: pc_n = a;
                    OPX_CALLR:  begin wen = 1'b1; dest = REG_RA; wd = r_pc; pc_n = a; end
                    OPX_ROLI:   begin wen = 1'b1; alu_op = ALU_ROL; alu_y = {27'b0, i5}; end
                    OPX_ROL:    begin wen = 1'b1; alu_op = ALU_ROL; end
                    OPX_ROR:    begin wen = 1'b1; alu_op = ALU_ROR; end
                    OPX_NOR:    begin wen = 1'b1; alu_op = ALU_NOR; end
                    OPX_AND:    begin wen = 1'b1; alu_op = ALU_AND; end
                    OPX_OR:     begin wen = 1'b1; alu_op = ALU_OR; end
                    OPX_XOR:    begin wen = 1'b1; alu_op = ALU_XOR; end
                    OPX_ADD:    wen = 1'b1;
                    OPX_SUB:    begin wen = 1'b1; alu_op = ALU_SUB; end
                    OPX_CMPGE:  begin wen = 1'b1; alu_op = ALU_GES; end
                    OPX_CMPLT:  begin wen = 1'b1; alu_op = ALU_LTS; end
                    OPX_CMPGEU: begin wen = 1'b1; alu_op = ALU_GEU; end
                    OPX_CMPLTU: begin wen = 1'b1; alu_op = ALU_LTU; end
                    OPX_CMPEQ:  begin wen = 1'b1; alu_op = ALU_EQ; end
                    OPX_CMPNE:  begin wen = 1'b1; alu_op = ALU_NE; end
                    OPX_SLLI:   begin wen = 1'b1; alu_op = ALU_SLL; alu_y = {27'b0, i5}; end
                    OPX_SLL:    begin wen = 1'b1; alu_op = ALU_SLL; end
                    OPX_SRLI:   begin wen = 1'b1; alu_op = ALU_SRL; alu_y = {27'b0, i5}; end
                    OPX_SRL:    begin wen = 1'b1; alu_op = ALU_SRL; end
                    OPX_SRAI:   begin wen = 1'b1; alu_op = ALU_SRA; alu_y = {27'b0, i5}; end
                    OPX_SRA:    begin wen = 1'b1; alu_op = ALU_SRA; end
                    OPX_NEXTPC: begin wen = 1'b1; wd = r_pc; end
                    OPX_RDCTL:  begin wen = 1'b1; wd = ctl_rd; end
                    OPX_WRCTL:  wrctl = 1'b1;
                    OPX_TRAP:   take_exc = 1'b1;
                    OPX_BREAK:  halt = 1'b1;
                    OPX_MUL:    go_mul = 1'b1;
                    OPX_MULXUU: begin go_mul = 1'b1; mul_hi = 1'b1; end
                    OPX_MULXSU: begin go_mul = 1'b1; mul_hi = 1'b1; sgn_a = 1'b1; end
                    OPX_MULXSS: begin
                        go_mul = 1'b1; mul_hi = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1;
                    end
                    OPX_DIVU:   go_div = (b != '0);
                    OPX_DIV:    begin go_div = (b != '0); div_sgn = 1'b1; end
                    default: ;
                endcase
            end
            OP_LDBU, OP_LDBUIO: begin is_ld = 1'b1; alu_y = s16; end
            OP_LDB, OP_LDBIO:   begin is_ld = 1'b1; alu_y = s16; kind = KIND_BS; end
            OP_LDHU, OP_LDHUIO: begin
                is_ld = 1'b1; alu_y = s16; size = SIZE_H; kind = KIND_HU;
            end
            OP_LDH, OP_LDHIO:   begin
                is_ld = 1'b1; alu_y = s16; size = SIZE_H; kind = KIND_HS;
            end
            OP_LDW, OP_LDWIO:   begin
                is_ld = 1'b1; alu_y = s16; size = SIZE_W; kind = KIND_W;
            end
            OP_STB, OP_STBIO: begin is_st = 1'b1; alu_y = s16; md = {24'b0, b[7:0]}; end
            OP_STH, OP_STHIO: begin
                is_st = 1'b1; alu_y = s16; size = SIZE_H; md = {16'b0, b[15:0]};
            end
            OP_STW, OP_STWIO: begin is_st = 1'b1; alu_y = s16; size = SIZE_W; md = b; end
            OP_ADDI:    begin wen = 1'b1; alu_y = s16; end
            OP_BR:      pc_n = br_tgt;
            OP_CMPGEI:  begin wen = 1'b1; alu_op = ALU_GES; alu_y = s16; end
            OP_CMPLTI:  begin wen = 1'b1; alu_op = ALU_LTS; alu_y = s16; end
            OP_CMPNEI:  begin wen = 1'b1; alu_op = ALU_NE; alu_y = s16; end
            OP_CMPEQI:  begin wen = 1'b1; alu_op = ALU_EQ; alu_y = s16; end
            OP_CMPGEUI: begin wen = 1'b1; alu_op = ALU_GEU; alu_y = {16'b0, u16}; end
            OP_CMPLTUI: begin wen = 1'b1; alu_op = ALU_LTU; alu_y = {16'b0, u16}; end
            OP_ANDI:    begin wen = 1'b1; alu_op = ALU_AND; alu_y = {16'b0, u16}; end
            OP_ORI:     begin wen = 1'b1; alu_op = ALU_OR; alu_y = {16'b0, u16}; end
            OP_XORI:    begin wen = 1'b1; alu_op = ALU_XOR; alu_y = {16'b0, u16}; end
            OP_ANDHI:   begin wen = 1'b1; alu_op = ALU_AND; alu_y = {u16, 16'b0}; end
            OP_ORHI:    begin wen = 1'b1; alu_op = ALU_OR; alu_y = {u16, 16'b0}; end
            OP_XORHI:   begin wen = 1'b1; alu_op = ALU_XOR; alu_y = {u16, 16'b0}; end
            OP_MULI:    begin go_mul = 1'b1; mul_y = s16; end
            OP_BGE:     begin br = 1'b1; alu_op = ALU_GES; end
            OP_BLT:     begin br = 1'b1; alu_op = ALU_LTS; end
            OP_BNE:     begin br = 1'b1; alu_op = ALU_NE; end
            OP_BEQ:     begin br = 1'b1; alu_op = ALU_EQ; end
            OP_BGEU:    begin br = 1'b1; alu_op = ALU_GEU; end
            OP_BLTU:    begin br = 1'b1; alu_op = ALU_LTU; end
            default: ;
        endcase
        if (br && alu_res[0]) pc_n = br_tgt;
    end

    assign exc_now = irq_due || take_exc;
    assign mx = {sgn_a & a[31], a};
    assign my = {sgn_b & mul_y[31], mul_y};
    assign prod_full = mx * my;

    assign div_ctl.start = (r_state == S_EXEC) && go_div && !exc_now;
    assign div_ctl.sgn   = div_sgn;

    rice_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_ctl),
        .i_dividend(a), .i_divisor(b), .o_done(div_done), .o_quot(div_q)
    );

    always_comb begin
        gpr_we = 1'b0; gpr_wa = r_dest; gpr_wd = div_q;
        priority if (r_state == S_IDLE) begin
            gpr_we = acc && i_in.func && r_load_pend && !r_halt && (r_load_dest != '0);
            gpr_wa = r_load_dest;
            gpr_wd = load_ext(r_load_kind, i_in.load_data);
        end else if (r_state == S_EXEC) begin
            if (exc_now) begin
                gpr_we = 1'b1; gpr_wa = REG_EA; gpr_wd = r_pc;
            end else begin
                gpr_we = wen && (dest != '0); gpr_wa = dest; gpr_wd = wd;
            end
        end else if (r_state == S_MUL) begin
            gpr_we = (r_dest != '0);
            gpr_wd = r_mul_hi ? r_prod[63:32] : r_prod[31:0];
        end else begin
            gpr_we = div_done && (r_dest != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_vec       <= VEC_RESET;
            r_halt      <= 1'b0;
            r_load_pend <= 1'b0;
            r_load_dest <= '0;
            r_load_kind <= KIND_BU;
            r_out_valid <= 1'b0;
            r_gpr_vld   <= '0;
            for (int k = 0; k < NUM_CTL_REGS; k++) r_ctl[k] <= '0;
        end else begin
            if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;
            if (gpr_we) r_gpr_vld[gpr_wa] <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_iw <= i_in.instr_word;
                        if (r_halt || i_in.func || r_load_pend) begin
                            if (!r_halt && i_in.func) r_load_pend <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_o_pc   <= r_pc;
                            r_o_mv   <= 1'b0;
                            r_o_mw   <= 1'b0;
                            r_o_ms   <= SIZE_B;
                            r_o_ma   <= '0;
                            r_o_md   <= '0;
                            r_o_wait <= r_load_pend && !(!r_halt && i_in.func);
                            r_o_halt <= r_halt;
                        end else begin
                            r_ctl[CTL_IPENDING] <= i_in.irq_lines;
                            r_pc    <= r_pc + 32'd4;
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    r_dest   <= dest;
                    r_mul_hi <= mul_hi;
                    r_prod   <= prod_full[63:0];
                    r_o_pc   <= pc_n;
                    r_o_mv   <= 1'b0;
                    r_o_mw   <= 1'b0;
                    r_o_ms   <= SIZE_B;
                    r_o_ma   <= '0;
                    r_o_md   <= '0;
                    r_o_wait <= 1'b0;
                    r_o_halt <= 1'b0;
                    if (exc_now) begin
                        r_ctl[CTL_ESTATUS] <= r_ctl[CTL_STATUS];
                        r_ctl[CTL_STATUS]  <= r_ctl[CTL_STATUS] & ~32'd3;
                        r_pc        <= r_vec;
                        r_o_pc      <= r_vec;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_pc <= pc_n;
                        if (eret) r_ctl[CTL_STATUS] <= r_ctl[CTL_ESTATUS];
                        if (wrctl && ({1'b0, i5} < 6'(NUM_CTL_REGS))) r_ctl[i5[CW-1:0]] <= a;
                        if (halt) begin
                            r_halt   <= 1'b1;
                            r_o_halt <= 1'b1;
                        end
                        if (is_ld) begin
                            r_load_pend <= 1'b1;
                            r_load_dest <= rb;
                            r_load_kind <= kind;
                            r_o_wait    <= 1'b1;
                        end
                        if (is_ld || is_st) begin
                            r_o_mv <= 1'b1;
                            r_o_mw <= is_st;
                            r_o_ms <= size;
                            r_o_ma <= alu_res;
                            r_o_md <= md;
                        end
                        priority if (go_mul) begin
                            r_state <= S_MUL;
                        end else if (go_div) begin
                            r_state <= S_DIV;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_MUL: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START) r_pc <= i_cfg_wdata;
                else if (i_cfg_idx == CFG_VECTOR) r_vec <= i_cfg_wdata;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.fetch_pc      = r_o_pc;
    assign o_out.mem_valid     = r_o_mv;
    assign o_out.mem_write     = r_o_mw;
    assign o_out.mem_size      = r_o_ms;
    assign o_out.mem_addr      = r_o_ma;
    assign o_out.mem_wdata     = r_o_md;
    assign o_out.awaiting_load = r_o_wait;
    assign o_out.cpu_halted    = r_o_halt;

    `RICE_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt, "halt flag cleared")
    `RICE_ASSERT_IMP(a_exec_no_load, i_clk, i_rst_n, r_state == S_EXEC, !r_load_pend, "exec with load pending")
    `RICE_ASSERT_IMP(a_div_state, i_clk, i_rst_n, div_done, r_state == S_DIV, "divider done outside divide state")
    `RICE_ASSERT_NXT(a_hold_idle, i_clk, i_rst_n, r_out_valid && !o_out.ready, r_state == S_IDLE, "sequencer ran with result pending")

endmodule

>>> test/tb.sv
// Testbench for risc_instruction_execute_core: directed and random instruction streams,
// checked word by word against an in-bench instruction-level predictor.
// Depends on rice_pkg, rice_in_if, rice_out_if and the core top level.
`timescale 1ns / 1ps
module tb;
    import rice_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [31:0] fetch_pc;
        logic        mem_valid;
        logic        mem_write;
        logic [1:0]  mem_size;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        awaiting_load;
        logic        cpu_halted;
    } core_result_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    rice_in_if  in_ch ();
    rice_out_if out_ch ();

    risc_instruction_execute_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // architectural state of the predicted core
    logic [31:0] gpr [32];
    logic [31:0] ctl [32];
    logic [31:0] pc_q;
    logic [31:0] start_q;
    logic [31:0] vector_q;
    bit          halted_q;
    bit          ld_pend_q;
    logic [4:0]  ld_dest_q;
    logic [2:0]  ld_kind_q;

    core_result_t expected_results [$];
    int errors;
    int words_sent;
    int results_seen;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_seen;
    int hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void wreg(input logic [4:0] r, input logic [31:0] v);
        if (r != 5'd0) gpr[r] = v;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        return (s == 0) ? v : ((v << s) | (v >> (6'd32 - s)));
    endfunction

    function automatic logic [31:0] mul_high(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'b0, a} * {32'b0, b};
        return p[63:32];
    endfunction

    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic void take_exception();
        ctl[CTL_ESTATUS] = ctl[CTL_STATUS];
        ctl[CTL_STATUS] = ctl[CTL_STATUS] & ~32'd3;
        wreg(REG_EA, pc_q);
        pc_q = vector_q;
    endfunction

    // executes one accepted word and queues the result it must produce
    function automatic void execute_word(input bit f, input logic [31:0] iw,
                                         input logic [31:0] ld, input logic [31:0] irq);
        core_result_t r;
        logic [5:0] op, opx;
        logic [4:0] ra, rb, rc, i5;
        logic [31:0] u16, s16, imm26, a, b, v, eaddr, sdata;
        bit is_ld, is_st;
        logic [1:0] sz;
        logic [2:0] kind;
        r = '0;
        is_ld = 0;
        is_st = 0;
        sz = SIZE_B;
        kind = KIND_BU;
        sdata = 0;
        if (!halted_q) begin
            if (f) begin
                if (ld_pend_q) begin
                    case (ld_kind_q)
                        KIND_BU: v = {24'b0, ld[7:0]};
                        KIND_BS: v = {{24{ld[7]}}, ld[7:0]};
                        KIND_HU: v = {16'b0, ld[15:0]};
                        KIND_HS: v = {{16{ld[15]}}, ld[15:0]};
                        default: v = ld;
                    endcase
                    wreg(ld_dest_q, v);
                    ld_pend_q = 0;
                end
            end else if (!ld_pend_q) begin
                op = iw[5:0];
                ra = iw[31:27];
                rb = iw[26:22];
                rc = iw[21:17];
                opx = iw[16:11];
                i5 = iw[10:6];
                u16 = {16'b0, iw[21:6]};
                s16 = {{16{iw[21]}}, iw[21:6]};
                imm26 = {6'b0, iw[31:6]};
                a = gpr[ra];
                b = gpr[rb];
                eaddr = a + s16;
                ctl[CTL_IPENDING] = irq;
                pc_q = pc_q + 4;
                if (ctl[CTL_STATUS][0] && ((ctl[CTL_IPENDING] & ctl[CTL_IENABLE]) != 0)) begin
                    take_exception();
                end else begin
                    case (op)
                        OP_CALL: begin
                            wreg(REG_RA, pc_q);
                            pc_q = (pc_q & 32'hf000_0000) | (imm26 << 2);
                        end
                        OP_JMPI: pc_q = (pc_q & 32'hf000_0000) | (imm26 << 2);
                        OP_RTYPE: begin
                            case (opx)
                                OPX_ERET: begin
                                    ctl[CTL_STATUS] = ctl[CTL_ESTATUS];
                                    pc_q = gpr[REG_EA];
                                end
                                OPX_ROLI: wreg(rc, rotl(a, i5));
                                OPX_ROL: wreg(rc, rotl(a, b[4:0]));
                                OPX_RET: pc_q = gpr[REG_RA];
                                OPX_NOR: wreg(rc, ~(a | b));
                                OPX_MULXUU: wreg(rc, mul_high(a, b));
                                OPX_CMPGE: wreg(rc, ($signed(a) < $signed(b)) ? 0 : 1);
                                OPX_ROR: wreg(rc, rotl(a, 5'(6'd32 - b[4:0])));
                                OPX_JMP: pc_q = a;
                                OPX_AND: wreg(rc, a & b);
                                OPX_CMPLT: wreg(rc, ($signed(a) < $signed(b)) ? 1 : 0);
                                OPX_SLLI: wreg(rc, a << i5);
                                OPX_SLL: wreg(rc, a << b[4:0]);
                                OPX_OR: wreg(rc, a | b);
                                OPX_MULXSU: wreg(rc, mul_high(a, b) - (a[31] ? b : 0));
                                OPX_CMPNE: wreg(rc, (a != b) ? 1 : 0);
                                OPX_SRLI: wreg(rc, a >> i5);
                                OPX_SRL: wreg(rc, a >> b[4:0]);
                                OPX_NEXTPC: wreg(rc, pc_q);
                                OPX_CALLR: begin
                                    wreg(REG_RA, pc_q);
                                    pc_q = a;
                                end
                                OPX_XOR: wreg(rc, a ^ b);
                                OPX_MULXSS: wreg(rc, mul_high(a, b) - (a[31] ? b : 0)
                                                 - (b[31] ? a : 0));
                                OPX_CMPEQ: wreg(rc, (a == b) ? 1 : 0);
                                OPX_DIVU: if (b != 0) wreg(rc, a / b);
                                OPX_DIV: if (b != 0) wreg(rc, sdiv(a, b));
                                OPX_RDCTL: wreg(rc, ctl[i5]);
                                OPX_MUL: wreg(rc, a * b);
                                OPX_CMPGEU: wreg(rc, (a >= b) ? 1 : 0);
                                OPX_TRAP: take_exception();
                                OPX_WRCTL: ctl[i5] = a;
                                OPX_CMPLTU: wreg(rc, (a < b) ? 1 : 0);
                                OPX_ADD: wreg(rc, a + b);
                                OPX_BREAK: halted_q = 1;
                                OPX_SUB: wreg(rc, a - b);
                                OPX_SRAI: wreg(rc, $signed(a) >>> i5);
                                OPX_SRA: wreg(rc, $signed(a) >>> b[4:0]);
                                default: ;
                            endcase
                        end
                        OP_LDBU, OP_LDBUIO: begin is_ld = 1; sz = SIZE_B; kind = KIND_BU; end
                        OP_LDB, OP_LDBIO: begin is_ld = 1; sz = SIZE_B; kind = KIND_BS; end
                        OP_LDHU, OP_LDHUIO: begin is_ld = 1; sz = SIZE_H; kind = KIND_HU; end
                        OP_LDH, OP_LDHIO: begin is_ld = 1; sz = SIZE_H; kind = KIND_HS; end
                        OP_LDW, OP_LDWIO: begin is_ld = 1; sz = SIZE_W; kind = KIND_W; end
                        OP_STB, OP_STBIO: begin is_st = 1; sz = SIZE_B; sdata = b & 32'hff; end
                        OP_STH, OP_STHIO: begin is_st = 1; sz = SIZE_H; sdata = b & 32'hffff; end
                        OP_STW, OP_STWIO: begin is_st = 1; sz = SIZE_W; sdata = b; end
                        OP_ADDI: wreg(rb, a + s16);
                        OP_BR: pc_q = pc_q + s16;
                        OP_CMPGEI: wreg(rb, ($signed(a) < $signed(s16)) ? 0 : 1);
                        OP_ANDI: wreg(rb, a & u16);
                        OP_BGE: if (!($signed(a) < $signed(b))) pc_q = pc_q + s16;
                        OP_CMPLTI: wreg(rb, ($signed(a) < $signed(s16)) ? 1 : 0);
                        OP_ORI: wreg(rb, a | u16);
                        OP_BLT: if ($signed(a) < $signed(b)) pc_q = pc_q + s16;
                        OP_CMPNEI: wreg(rb, (a != s16) ? 1 : 0);
                        OP_XORI: wreg(rb, a ^ u16);
                        OP_BNE: if (a != b) pc_q = pc_q + s16;
                        OP_CMPEQI: wreg(rb, (a == s16) ? 1 : 0);
                        OP_MULI: wreg(rb, a * s16);
                        OP_BEQ: if (a == b) pc_q = pc_q + s16;
                        OP_CMPGEUI: wreg(rb, (a >= u16) ? 1 : 0);
                        OP_ANDHI: wreg(rb, a & (u16 << 16));
                        OP_BGEU: if (a >= b) pc_q = pc_q + s16;
                        OP_CMPLTUI: wreg(rb, (a < u16) ? 1 : 0);
                        OP_ORHI: wreg(rb, a | (u16 << 16));
                        OP_BLTU: if (a < b) pc_q = pc_q + s16;
                        OP_XORHI: wreg(rb, a ^ (u16 << 16));
                        default: ;
                    endcase
                    if (is_ld) begin
                        r.mem_valid = 1;
                        r.mem_size = sz;
                        r.mem_addr = eaddr;
                        ld_pend_q = 1;
                        ld_dest_q = rb;
                        ld_kind_q = kind;
                    end else if (is_st) begin
                        r.mem_valid = 1;
                        r.mem_write = 1;
                        r.mem_size = sz;
                        r.mem_addr = eaddr;
                        r.mem_wdata = sdata;
                    end
                end
            end
        end
        r.fetch_pc = pc_q;
        r.awaiting_load = ld_pend_q;
        r.cpu_halted = halted_q;
        expected_results.push_back(r);
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] ra,
                                          input logic [4:0] rb, input logic [15:0] imm);
        return {ra, rb, imm, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [5:0] opx, input logic [4:0] ra,
                                          input logic [4:0] rb, input logic [4:0] rc,
                                          input logic [4:0] i5);
        return {ra, rb, rc, opx, i5, OP_RTYPE};
    endfunction

    // sends one word; valid stays high into the next word unless the sender idles
    task automatic send_word(input bit f, input logic [31:0] iw, input logic [31:0] ld,
                             input logic [31:0] irq);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.instr_word <= iw;
        in_ch.load_data <= ld;
        in_ch.irq_lines <= irq;
        do @(posedge i_clk); while (!in_ch.ready);
        execute_word(f, iw, ld, irq);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [31:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_START) begin
            start_q = val;
            pc_q = val;
        end else begin
            vector_q = val;
        end
    endtask

    // receiver: random stalls plus a long hold-off when the test requests one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = 300;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        core_result_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected, fetch_pc %h", out_ch.fetch_pc);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (out_ch.fetch_pc !== e.fetch_pc) begin
                    $error("fetch_pc exp %h got %h", e.fetch_pc, out_ch.fetch_pc); errors++;
                end
                if (out_ch.mem_valid !== e.mem_valid) begin
                    $error("mem_valid exp %b got %b", e.mem_valid, out_ch.mem_valid); errors++;
                end
                if (out_ch.mem_write !== e.mem_write) begin
                    $error("mem_write exp %b got %b", e.mem_write, out_ch.mem_write); errors++;
                end
                if (out_ch.mem_size !== e.mem_size) begin
                    $error("mem_size exp %0d got %0d", e.mem_size, out_ch.mem_size); errors++;
                end
                if (out_ch.mem_addr !== e.mem_addr) begin
                    $error("mem_addr exp %h got %h", e.mem_addr, out_ch.mem_addr); errors++;
                end
                if (out_ch.mem_wdata !== e.mem_wdata) begin
                    $error("mem_wdata exp %h got %h", e.mem_wdata, out_ch.mem_wdata); errors++;
                end
                if (out_ch.awaiting_load !== e.awaiting_load) begin
                    $error("awaiting_load exp %b got %b", e.awaiting_load, out_ch.awaiting_load);
                    errors++;
                end
                if (out_ch.cpu_halted !== e.cpu_halted) begin
                    $error("cpu_halted exp %b got %b", e.cpu_halted, out_ch.cpu_halted);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [4:0] rreg();
        return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 7));
    endfunction

    function automatic logic [15:0] rimm();
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_instr();
        logic [5:0] i_ops [26];
        logic [5:0] ld_ops [10];
        logic [5:0] st_ops [6];
        logic [5:0] r_ops [36];
        logic [31:0] w;
        int k;
        i_ops = '{OP_ADDI, OP_BR, OP_CMPGEI, OP_ANDI, OP_BGE, OP_CMPLTI, OP_ORI, OP_BLT,
                  OP_CMPNEI, OP_XORI, OP_BNE, OP_CMPEQI, OP_MULI, OP_BEQ, OP_CMPGEUI,
                  OP_ANDHI, OP_BGEU, OP_CMPLTUI, OP_ORHI, OP_BLTU, OP_XORHI, OP_ORHI,
                  OP_ADDI, OP_ORI, OP_XORHI, OP_MULI};
        ld_ops = '{OP_LDBU, OP_LDBUIO, OP_LDB, OP_LDBIO, OP_LDHU, OP_LDHUIO, OP_LDH,
                   OP_LDHIO, OP_LDW, OP_LDWIO};
        st_ops = '{OP_STB, OP_STBIO, OP_STH, OP_STHIO, OP_STW, OP_STWIO};
        r_ops = '{OPX_ERET, OPX_ROLI, OPX_ROL, OPX_RET, OPX_NOR, OPX_MULXUU, OPX_CMPGE,
                  OPX_ROR, OPX_JMP, OPX_AND, OPX_CMPLT, OPX_SLLI, OPX_SLL, OPX_OR,
                  OPX_MULXSU, OPX_CMPNE, OPX_SRLI, OPX_SRL, OPX_NEXTPC, OPX_CALLR, OPX_XOR,
                  OPX_MULXSS, OPX_CMPEQ, OPX_DIVU, OPX_DIV, OPX_RDCTL, OPX_MUL, OPX_CMPGEU,
                  OPX_TRAP, OPX_WRCTL, OPX_CMPLTU, OPX_ADD, OPX_SUB, OPX_SRAI, OPX_SRA,
                  OPX_DIVU};
        k = $urandom_range(99);
        if (k < 10) w = enc_i(ld_ops[$urandom_range(9)], rreg(), rreg(), rimm());
        else if (k < 18) w = enc_i(st_ops[$urandom_range(5)], rreg(), rreg(), rimm());
        else if (k < 52) w = enc_r(r_ops[$urandom_range(35)], rreg(), rreg(), rreg(),
                                   5'($urandom));
        else if (k < 88) w = enc_i(i_ops[$urandom_range(25)], rreg(), rreg(), rimm());
        else if (k < 92) w = {$urandom_range(1) ? 26'($urandom) : 26'h3ff_ffff,
                              $urandom_range(1) ? OP_CALL : OP_JMPI};
        else w = $urandom;
        // break halts for good, so it only appears at the end of the run
        if (w[5:0] == OP_RTYPE && w[16:11] == OPX_BREAK) w[11] = ~w[11];
        return w;
    endfunction

    task automatic run_random(input int n);
        logic [31:0] irq;
        for (int i = 0; i < n; i++) begin
            irq = ($urandom_range(4) == 0) ? $urandom : 32'd0;
            if (ld_pend_q && $urandom_range(9) != 0)
                send_word(1'b1, $urandom, $urandom, $urandom);
            else if ($urandom_range(19) == 0)
                send_word(1'b1, $urandom, $urandom, irq);
            else
                send_word(1'b0, random_instr(), $urandom, irq);
        end
    endtask

    task automatic test_directed();
        send_word(0, enc_i(OP_ORHI, 0, 1, 16'h8000), 0, 0);
        send_word(0, enc_i(OP_ADDI, 0, 2, 16'hffff), 0, 0);
        send_word(0, enc_i(OP_ORI, 0, 3, 16'hffff), 0, 0);
        send_word(0, enc_r(OPX_DIV, 1, 2, 4, 0), 0, 0);
        send_word(0, enc_r(OPX_DIVU, 2, 0, 3, 0), 0, 0);
        send_word(0, enc_r(OPX_MULXSS, 1, 2, 6, 0), 0, 0);
        send_word(0, enc_r(OPX_MULXSU, 2, 1, 7, 0), 0, 0);
        send_word(0, enc_r(OPX_MULXUU, 2, 2, 8, 0), 0, 0);
        send_word(0, enc_r(OPX_RDCTL, 0, 0, 9, 31), 0, 0);
        send_word(0, enc_i(OP_LDB, 2, 0, 16'h7fff), 0, 0);
        send_word(0, enc_i(OP_ADDI, 0, 5, 16'h0001), 0, 0);
        send_word(1, 0, 32'hffff_ff80, 0);
        send_word(1, 0, 32'h1234_5678, 0);
        send_word(0, enc_i(OP_LDHIO, 1, 10, 16'h0000), 0, 0);
        send_word(1, 0, 32'h0000_8000, 0);
        send_word(0, enc_i(OP_STW, 1, 2, 16'h8000), 0, 0);
        send_word(0, enc_i(OP_STB, 0, 2, 16'h0003), 0, 0);
        send_word(0, enc_i(OP_STH, 2, 2, 16'hfffe), 0, 0);
        send_word(0, 32'hffff_ffff, 0, 0);
        send_word(0, enc_r(OPX_CALLR, 31, 0, 0, 0), 0, 0);
        send_word(0, enc_r(OPX_NEXTPC, 0, 0, 11, 0), 0, 0);
        send_word(0, enc_r(OPX_RET, 0, 0, 0, 0), 0, 0);
        send_word(0, enc_r(OPX_WRCTL, 2, 0, 0, 5'(CTL_IENABLE)), 0, 0);
        send_word(0, enc_r(OPX_WRCTL, 2, 0, 0, 5'(CTL_STATUS)), 0, 0);
        send_word(0, enc_i(OP_ADDI, 0, 12, 16'h0005), 0, 32'h8000_0001);
        send_word(0, enc_r(OPX_ERET, 0, 0, 0, 0), 0, 0);
        send_word(0, enc_r(OPX_TRAP, 0, 0, 0, 0), 0, 0);
        send_word(0, enc_r(OPX_WRCTL, 0, 0, 0, 5'(CTL_STATUS)), 0, 0);
    endtask

    task automatic test_config();
        cfg_write(CFG_START, 32'hffff_fffc);
        send_word(0, 32'hffff_ffff, 0, 0);
        cfg_write(CFG_VECTOR, 32'hffff_ffff);
        send_word(0, enc_r(OPX_TRAP, 0, 0, 0, 0), 0, 0);
        cfg_write(CFG_VECTOR, 32'h0000_0000);
        send_word(0, enc_r(OPX_TRAP, 0, 0, 0, 0), 0, 0);
        cfg_write(CFG_START, 32'h0000_0000);
        send_word(0, enc_r(OPX_NEXTPC, 0, 0, 13, 0), 0, 0);
        cfg_write(CFG_START, 32'h1000_0400);
        cfg_write(CFG_VECTOR, VEC_RESET);
        run_random(40);
    endtask

    task automatic test_random_phases();
        send_idle_pct = 34; recv_idle_pct = 52;
        run_random(580);
        send_idle_pct = 52; recv_idle_pct = 34;
        run_random(580);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(580);
    endtask

    task automatic test_pressure();
        send_idle_pct = 0; recv_idle_pct = 10;
        hold_req++;
        run_random(25);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_results.size() == 0);
        run_random(25);
    endtask

    task automatic test_halt();
        send_word(0, enc_r(OPX_BREAK, 0, 0, 0, 0), 0, 0);
        send_word(0, enc_i(OP_ADDI, 0, 1, 16'h0001), 0, 32'hffff_ffff);
        send_word(1, 0, 32'hdead_beef, 0);
        send_word(0, enc_i(OP_LDW, 0, 1, 16'h0000), 0, 0);
    endtask

    initial begin
        for (int i = 0; i < 32; i++) begin
            gpr[i] = 0;
            ctl[i] = 0;
        end
        start_q = 0;
        vector_q = VEC_RESET;
        pc_q = 0;
        halted_q = 0;
        ld_pend_q = 0;
        ld_dest_q = 0;
        ld_kind_q = KIND_BU;
        errors = 0;
        words_sent = 0;
        results_seen = 0;
        cycles = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_cnt = 0;
        send_idle_pct = 34;
        recv_idle_pct = 52;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_START;
        i_cfg_wdata <= 32'd0;
        in_ch.valid <= 1'b0;
        in_ch.func <= 1'b0;
        in_ch.instr_word <= 32'd0;
        in_ch.load_data <= 32'd0;
        in_ch.irq_lines <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config();
        test_random_phases();
        test_pressure();
        test_halt();

        in_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("tb: %0d words sent, %0d results checked over directed, config,",
                 words_sent, results_seen);
        $display("tb: random idle phases, back-pressure and halt; %0d mismatches", errors);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
